>>> src/scl_pkg.sv
// Shared types, character codes and the mnemonic table of the command line parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package scl_pkg;

    // default limits, handed to the top level parameters
    localparam int SCL_MAX_FIELDS  = 8;
    localparam int SCL_FIELD_CHARS = 10;
    localparam int SCL_LINE_BYTES  = 64;

    localparam int CODE_W  = 7;
    localparam int INDEX_W = 3;
    localparam int VALUE_W = 30;

    // parse phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_NEED2 = 3'd1;
    localparam logic [2:0] PH_NEED3 = 3'd2;
    localparam logic [2:0] PH_COMMA = 3'd3;
    localparam logic [2:0] PH_FIELD = 3'd4;
    localparam logic [2:0] PH_STOP  = 3'd5;

    // command codes of the two-letter mnemonics
    localparam logic [CODE_W-1:0] CMD_WR = 7'h01;
    localparam logic [CODE_W-1:0] CMD_RD = 7'h02;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
        logic               done;
        logic               err;
    } t_result;

    typedef struct packed {
        logic              hit;
        logic [CODE_W-1:0] code;
    } t_mnem;

    // three-letter mnemonic lookup, first letter in the top byte
    function automatic t_mnem scl_mnem_lookup(input logic [23:0] chars);
        t_mnem m;
        m.hit  = 1'b1;
        m.code = '0;
        case (chars)
            "GeP":   m.code = 7'h45;
            "SeP":   m.code = 7'h46;
            "ZeP":   m.code = 7'h47;
            "SPW":   m.code = 7'h48;
            "PWH":   m.code = 7'h49;
            "PWL":   m.code = 7'h50;
            "SeF":   m.code = 7'h51;
            "SeB":   m.code = 7'h52;
            "StE":   m.code = 7'h53;
            "Mmd":   m.code = 7'h54;
            "Amd":   m.code = 7'h55;
            "rCP":   m.code = 7'h56;
            "MFw":   m.code = 7'h57;
            "MBk":   m.code = 7'h58;
            "MRp":   m.code = 7'h59;
            "MLp":   m.code = 7'h60;
            "TWI":   m.code = 7'h61;
            default: m.hit  = 1'b0;
        endcase
        return m;
    endfunction

endpackage

>>> src/serial_command_line_parser.sv
// Top level of the serial command line parser: input register, parse core, result register.
// Depends on scl_pkg, scl_parse_core and scl_out_reg.
//
//  channel  | dir | tdata (low bit up)                          | tlast     | tuser
//  s_axis   | in  | line_byte[7:0]                              | -         | line_start
//  m_axis   | out | command_code[6:0] field_index[9:7]          | line_done | parse_error
//           |     | field_value[39:10]                          |           |
//
// One byte per cycle while m_axis is not stalled; a result leaves through the result register.
// All parse work for a byte is one pass through the core between the input and result registers.
// Synchronous active-low reset returns the parser to idle and empties both registers.
// A stalled result holds both stages; s_axis_tready reopens as soon as m_axis_tready does.
`timescale 1ns / 1ps

module serial_command_line_parser
    import scl_pkg::*;
#(
    parameter int MAX_FIELDS  = SCL_MAX_FIELDS,
    parameter int FIELD_CHARS = SCL_FIELD_CHARS,
    parameter int LINE_BYTES  = SCL_LINE_BYTES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // line_byte[7:0]
    input  logic                              s_axis_tuser,  // line_start
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // command_code[6:0], field_index[9:7], field_value[39:10]
    output logic [CODE_W+INDEX_W+VALUE_W-1:0] m_axis_tdata,
    output logic                              m_axis_tlast,  // line_done
    output logic                              m_axis_tuser   // parse_error
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;
    logic       w_free;
    logic       w_step;
    logic       w_res_valid;
    t_result    w_res;

    assign w_step        = r_in_valid && w_free;
    assign s_axis_tready = !r_in_valid || w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
    end

    scl_parse_core #(
        .MAX_FIELDS  (MAX_FIELDS),
        .FIELD_CHARS (FIELD_CHARS),
        .LINE_BYTES  (LINE_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_byte      (r_in_byte),
        .i_start     (r_in_start),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    scl_out_reg u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_step),
        .i_res_valid   (w_res_valid),
        .i_res         (w_res),
        .o_free        (w_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_free) |=> (r_in_valid && $stable(r_in_byte) && $stable(r_in_start)))
        else $error("input register lost a waiting item");

    a_no_step_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !w_step)
        else $error("core advanced while result register was blocked");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0 && !m_axis_tlast))
        else $error("error result carries field data");

endmodule

>>> src/scl_parse_core.sv
// Parser state and the per-byte next-state / result logic.
// Depends on scl_pkg (phases, character codes, mnemonic lookup, t_result).
`timescale 1ns / 1ps

module scl_parse_core
    import scl_pkg::*;
#(
    parameter int MAX_FIELDS  = SCL_MAX_FIELDS,
    parameter int FIELD_CHARS = SCL_FIELD_CHARS,
    parameter int LINE_BYTES  = SCL_LINE_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_start,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam int FC_W = $clog2(MAX_FIELDS);
    localparam int CC_W = $clog2(FIELD_CHARS + 1);
    localparam int LP_W = $clog2(LINE_BYTES + 1);

    logic [2:0]         r_phase, n_phase;
    logic [15:0]        r_lead, n_lead;
    logic [CODE_W-1:0]  r_code, n_code;
    logic [FC_W-1:0]    r_fc, n_fc;
    logic [CC_W-1:0]    r_cc, n_cc;
    logic [VALUE_W-1:0] r_acc, n_acc;
    logic               r_pt, n_pt;
    logic [LP_W-1:0]    r_pos, n_pos;

    logic               w_is_digit;
    logic [VALUE_W-1:0] w_acc10;
    t_mnem              w_mnem;

    assign w_is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign w_acc10    = {r_acc[VALUE_W-4:0], 3'b000} + {r_acc[VALUE_W-2:0], 1'b0}
                      + {{(VALUE_W-4){1'b0}}, i_byte[3:0]};
    assign w_mnem     = scl_mnem_lookup({r_lead, i_byte});

    always_comb begin
        n_phase     = r_phase;
        n_lead      = r_lead;
        n_code      = r_code;
        n_fc        = r_fc;
        n_cc        = r_cc;
        n_acc       = r_acc;
        n_pt        = r_pt;
        n_pos       = r_pos;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_start) begin
            n_phase = PH_NEED2;
            n_lead  = {8'h00, i_byte};
            n_code  = '0;
            n_fc    = '0;
            n_cc    = '0;
            n_acc   = '0;
            n_pt    = 1'b0;
            n_pos   = LP_W'(1);
        end else if (r_phase == PH_IDLE || r_phase >= PH_STOP) begin
            // outside a line: byte dropped
        end else if (r_pos >= LP_W'(LINE_BYTES)) begin
            o_res_valid = 1'b1;
            o_res.err   = 1'b1;
            n_phase     = PH_STOP;
        end else begin
            n_pos = r_pos + LP_W'(1);
            case (r_phase)
                PH_NEED2: begin
                    n_lead = {r_lead[7:0], i_byte};
                    if (n_lead == "WR") begin
                        n_code  = CMD_WR;
                        n_phase = PH_COMMA;
                    end else if (n_lead == "RD") begin
                        n_code  = CMD_RD;
                        n_phase = PH_COMMA;
                    end else begin
                        n_phase = PH_NEED3;
                    end
                end
                PH_NEED3: begin
                    if (w_mnem.hit) begin
                        n_code  = w_mnem.code;
                        n_phase = PH_COMMA;
                    end else begin
                        o_res_valid = 1'b1;
                        o_res.err   = 1'b1;
                        n_phase     = PH_STOP;
                    end
                end
                PH_COMMA: begin
                    if (i_byte == CH_COMMA) begin
                        n_phase = PH_FIELD;
                        n_fc    = '0;
                        n_cc    = '0;
                        n_acc   = '0;
                        n_pt    = 1'b0;
                    end else begin
                        o_res_valid = 1'b1;
                        o_res.err   = 1'b1;
                        n_phase     = PH_STOP;
                    end
                end
                PH_FIELD: begin
                    if (i_byte == CH_COMMA || i_byte == CH_SEMI) begin
                        o_res_valid = 1'b1;
                        if (r_fc >= FC_W'(MAX_FIELDS - 1)) begin
                            // too many fields: error in place of the field
                            o_res.err = 1'b1;
                            n_phase   = PH_STOP;
                        end else begin
                            o_res.code  = r_code;
                            o_res.index = INDEX_W'(r_fc);
                            o_res.value = r_acc;
                            o_res.done  = (i_byte == CH_SEMI);
                            n_fc        = r_fc + FC_W'(1);
                            n_cc        = '0;
                            n_acc       = '0;
                            n_pt        = 1'b0;
                            n_phase     = (i_byte == CH_SEMI) ? PH_STOP : PH_FIELD;
                        end
                    end else if (i_byte == CH_POINT || w_is_digit) begin
                        if (i_byte == CH_POINT) begin
                            n_pt = 1'b1;
                        end else if (!r_pt) begin
                            n_acc = w_acc10;
                        end
                        n_cc = r_cc + CC_W'(1);
                        if (r_cc >= CC_W'(FIELD_CHARS - 1)) begin
                            o_res_valid = 1'b1;
                            o_res.err   = 1'b1;
                            n_phase     = PH_STOP;
                        end
                    end else begin
                        o_res_valid = 1'b1;
                        o_res.err   = 1'b1;
                        n_phase     = PH_STOP;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_lead  <= '0;
            r_code  <= '0;
            r_fc    <= '0;
            r_cc    <= '0;
            r_acc   <= '0;
            r_pt    <= 1'b0;
            r_pos   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_lead  <= n_lead;
            r_code  <= n_code;
            r_fc    <= n_fc;
            r_cc    <= n_cc;
            r_acc   <= n_acc;
            r_pt    <= n_pt;
            r_pos   <= n_pos;
        end
    end

    a_err_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_valid && o_res.err) |=> (r_phase == PH_STOP))
        else $error("error result did not stop the line");

    a_res_from_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.err) |-> (r_phase == PH_FIELD && !i_start))
        else $error("field result outside the field phase");

    a_fc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc <= FC_W'(MAX_FIELDS - 1))
        else $error("field count past its limit");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LP_W'(LINE_BYTES))
        else $error("line position past its limit");

endmodule

>>> src/scl_out_reg.sv
// Result register feeding the master stream side.
// Depends on scl_pkg (t_result and field widths).
`timescale 1ns / 1ps

module scl_out_reg
    import scl_pkg::*;
(
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  logic                               i_res_valid,
    input  t_result                            i_res,
    output logic                               o_free,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [CODE_W+INDEX_W+VALUE_W-1:0]  m_axis_tdata,
    output logic                               m_axis_tlast,
    output logic                               m_axis_tuser
);

    logic    r_valid;
    t_result r_res;

    // slot can take a new result when empty or being drained this cycle
    assign o_free = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load && i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {r_res.value, r_res.index, r_res.code};
    assign m_axis_tlast  = r_res.done;
    assign m_axis_tuser  = r_res.err;

endmodule
